FILE: sv/pcorr_pkg.sv
// Shared types, codes and widths for the Pearson correlation block.
`default_nettype none
package pcorr_pkg;

  localparam int SUM_W  = 24;
  localparam int SQ_W   = 40;
  localparam int DIF_W  = 49;
  localparam int MAG_W  = 48;
  localparam int PROD_W = 96;
  localparam int QUO_W  = 29;
  localparam int ROOT_W = 15;
  localparam int REM_W  = 17;

  localparam logic [4:0] DIV_STEPS  = 5'd29;
  localparam logic [4:0] SQRT_STEPS = 5'd15;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // product schedule
  localparam logic [2:0] MS_NSXY = 3'd0;
  localparam logic [2:0] MS_SXSY = 3'd1;
  localparam logic [2:0] MS_NSXX = 3'd2;
  localparam logic [2:0] MS_SXSX = 3'd3;
  localparam logic [2:0] MS_NSYY = 3'd4;
  localparam logic [2:0] MS_SYSY = 3'd5;
  localparam logic [2:0] MS_NUM2 = 3'd6;
  localparam logic [2:0] MS_VXVY = 3'd7;

  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic               vector_absent;
    logic               last_element;
  } in_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_START, S_MUL_RUN, S_DIV, S_SQRT, S_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       mul_start;
    logic [2:0] sel;
    logic       div_step;
    logic       sqrt_step;
    logic       first;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/pcorr_mul.sv
// Shift-add multiplier, one operand bit per cycle.
`default_nettype none
module pcorr_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [pcorr_pkg::MAG_W-1:0]  a,
  input  wire logic [pcorr_pkg::MAG_W-1:0]  b,
  output logic                              done,
  output logic [pcorr_pkg::PROD_W-1:0]      product
);
  import pcorr_pkg::*;

  logic [MAG_W-1:0] a_r, hi_r, lo_r, hi_nxt, lo_nxt;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [MAG_W:0]   sum;

  always_comb begin
    sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    hi_nxt = sum[MAG_W:1];
    lo_nxt = {sum[0], lo_r[MAG_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};
endmodule
`default_nettype wire

FILE: sv/pcorr_dp.sv
// Datapath: accumulators, product scheduling, divider, square root, output register.
`default_nettype none
module pcorr_dp #(
  parameter int MAX_ELEMENTS = 256,
  parameter int CNT_W        = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcorr_pkg::cmd_t   cmd,
  output pcorr_pkg::sts_t        sts,
  input  wire pcorr_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pcorr_pkg::out_t        out_data
);
  import pcorr_pkg::*;

  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  logic signed [SQ_W-1:0]  sxx_r, syy_r, sxy_r;
  logic                    absent_r;

  logic signed [DIF_W-1:0]  t1_r, num_r, vx_r, vy_r;
  logic [PROD_W-1:0]        n2_r, p_r;
  logic [PROD_W:0]          rem_r, rem_sh;
  logic [QUO_W-1:0]         q_r, q_base;
  logic [29:0]              src_r, src_cur;
  logic [ROOT_W-1:0]        root_r, root_cur;
  logic [REM_W-1:0]         srem_r, srem_cur;
  logic [REM_W+1:0]         srem_sh, trial;

  logic                     out_valid_r;
  out_t                     out_r;

  logic signed [DIF_W-1:0]  opa, opb;
  logic [MAG_W-1:0]         mag_a, mag_b;
  logic                     neg;
  logic                     mul_done;
  logic [PROD_W-1:0]        prod_u;
  logic signed [PROD_W:0]   prod_s, diff;
  logic signed [DIF_W-1:0]  n_ext;
  logic signed [31:0]       xx, yy, xy;
  logic [1:0]               st;

  assign n_ext = DIF_W'($signed({1'b0, cnt_r}));
  assign xx    = in_data.x_sample * in_data.x_sample;
  assign yy    = in_data.y_sample * in_data.y_sample;
  assign xy    = in_data.x_sample * in_data.y_sample;

  always_comb begin
    case (cmd.sel)
      MS_NSXY: begin opa = n_ext;            opb = DIF_W'(sxy_r); end
      MS_SXSY: begin opa = DIF_W'(sx_r);     opb = DIF_W'(sy_r);  end
      MS_NSXX: begin opa = n_ext;            opb = DIF_W'(sxx_r); end
      MS_SXSX: begin opa = DIF_W'(sx_r);     opb = DIF_W'(sx_r);  end
      MS_NSYY: begin opa = n_ext;            opb = DIF_W'(syy_r); end
      MS_SYSY: begin opa = DIF_W'(sy_r);     opb = DIF_W'(sy_r);  end
      MS_NUM2: begin opa = num_r;            opb = num_r;         end
      MS_VXVY: begin opa = vx_r;             opb = vy_r;          end
      default: begin opa = '0;               opb = '0;            end
    endcase
    mag_a = opa[DIF_W-1] ? MAG_W'(-opa) : opa[MAG_W-1:0];
    mag_b = opb[DIF_W-1] ? MAG_W'(-opb) : opb[MAG_W-1:0];
    neg   = opa[DIF_W-1] ^ opb[DIF_W-1];
  end

  pcorr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mul_start),
    .a       (mag_a),
    .b       (mag_b),
    .done    (mul_done),
    .product (prod_u)
  );

  always_comb begin
    prod_s = neg ? -$signed({1'b0, prod_u}) : $signed({1'b0, prod_u});
    diff   = (PROD_W+1)'(t1_r) - prod_s;
    // divider: first step compares the bare numerator, later ones shift in a zero
    rem_sh = cmd.first ? {1'b0, n2_r} : {rem_r[PROD_W-1:0], 1'b0};
    q_base = cmd.first ? '0 : q_r;
    // square root, two radicand bits per step
    src_cur  = cmd.first ? {1'b0, q_r} : src_r;
    root_cur = cmd.first ? '0 : root_r;
    srem_cur = cmd.first ? '0 : srem_r;
    srem_sh  = {srem_cur, src_cur[29:28]};
    trial    = (REM_W+2)'({root_cur, 2'b01});
    if (absent_r)                   st = ST_ABSENT;
    else if (vx_r <= 0 || vy_r <= 0) st = ST_ZERO;
    else                            st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      sxx_r    <= '0;
      syy_r    <= '0;
      sxy_r    <= '0;
      absent_r <= 1'b0;
    end else if (cmd.finish) begin
      cnt_r    <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      sxx_r    <= '0;
      syy_r    <= '0;
      sxy_r    <= '0;
      absent_r <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.vector_absent) absent_r <= 1'b1;
      if (cnt_r < CNT_W'(MAX_ELEMENTS)) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sx_r  <= sx_r + SUM_W'(in_data.x_sample);
        sy_r  <= sy_r + SUM_W'(in_data.y_sample);
        sxx_r <= sxx_r + SQ_W'(xx);
        syy_r <= syy_r + SQ_W'(yy);
        sxy_r <= sxy_r + SQ_W'(xy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.sel)
        MS_NSXY, MS_NSXX, MS_NSYY: t1_r <= DIF_W'(prod_s);
        MS_SXSY: num_r <= DIF_W'(diff);
        MS_SXSX: vx_r  <= DIF_W'(diff);
        MS_SYSY: vy_r  <= DIF_W'(diff);
        MS_NUM2: n2_r  <= prod_u;
        MS_VXVY: p_r   <= prod_u;
        default: t1_r  <= t1_r;
      endcase
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, p_r}) begin
        rem_r <= rem_sh - {1'b0, p_r};
        q_r   <= {q_base[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_base[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_step) begin
      src_r <= {src_cur[27:0], 2'b00};
      if (srem_sh >= trial) begin
        srem_r <= REM_W'(srem_sh - trial);
        root_r <= {root_cur[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= REM_W'(srem_sh);
        root_r <= {root_cur[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_r.status      <= st;
      out_r.correlation <= (st != ST_OK) ? '0 :
                           num_r[DIF_W-1] ? -$signed({1'b0, root_r}) :
                           $signed({1'b0, root_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)           out_valid_r <= 1'b0;
    else if (cmd.finish)  out_valid_r <= 1'b1;
    else if (!out_stall)  out_valid_r <= 1'b0;
  end

  assign sts.mul_done = mul_done;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
endmodule
`default_nettype wire

FILE: sv/pcorr_ctrl.sv
// Controller: sequences accumulation, the product schedule, divide and square root.
`default_nettype none
module pcorr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  output logic                  in_stall,
  output pcorr_pkg::cmd_t       cmd,
  input  wire pcorr_pkg::sts_t  sts
);
  import pcorr_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = MS_NSXY;
        if (in_valid && in_last) state_nxt = S_MUL_START;
      end
      S_MUL_START: state_nxt = S_MUL_RUN;
      S_MUL_RUN: begin
        if (sts.mul_done) begin
          cnt_nxt = '0;
          if (idx_r == MS_VXVY) begin
            state_nxt = S_DIV;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = S_MUL_START;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == DIV_STEPS - 5'd1) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_SQRT: begin
        if (cnt_r == SQRT_STEPS - 5'd1) state_nxt = S_DONE;
        else                            cnt_nxt   = cnt_r + 5'd1;
      end
      S_DONE: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = idx_r;
    cmd.first     = (cnt_r == 5'd0);
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.mul_start = (state_r == S_MUL_START);
    cmd.div_step  = (state_r == S_DIV);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.finish    = (state_r == S_DONE) && sts.out_free;
    in_stall      = (state_r != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/pearson_correlation.sv
// Pearson correlation of paired Q8.8 sample streams, result in Q1.14.
// Input channel: one (x, y) pair per item with vector_absent and last_element
// flags. Pairs are accepted one per cycle while the block is idle; pairs past
// MAX_ELEMENTS are dropped from the sums.
// The item flagged last starts the result computation: eight 48x48 products on
// one shift-add multiplier, a 29-step restoring divide and a 15-step square
// root; the result register loads once all of these have finished, and
// in_stall stays high from the last item until that load.
// Output channel: one item per vector, correlation and status (0 ok, 1 zero
// variance, 2 vector absent). The output register frees the input side: new
// pairs are accepted while a result waits; a second result waits in the
// controller until the first has been taken. A stalled result holds.
// Reset (rst_n low at a clock edge) clears accumulators, controller and output valid.
`default_nettype none
module pearson_correlation #(
  parameter int MAX_ELEMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pcorr_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pcorr_pkg::out_t        out_data
);
  import pcorr_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  cmd_t cmd;
  sts_t sts;

  pcorr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_element),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pcorr_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire
